// ===== hw/rtl/timed_motor_pwm_envelope_assert.svh =====
// Assertion macros shared by the timed motor PWM envelope RTL.
// Included by bare file name; needs nothing else.
`ifndef TIMED_MOTOR_PWM_ENVELOPE_ASSERT_SVH
`define TIMED_MOTOR_PWM_ENVELOPE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TMPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TMPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tmpe_pkg.sv =====
// Package for the timed motor PWM envelope: codes, widths, state and bus types.
// No dependencies; used by the controller, datapath and top level of the block.
package tmpe_pkg;

  // Opcodes of an input transaction
  localparam logic [1:0] OpTick = 2'd0;
  localparam logic [1:0] OpRun  = 2'd1;
  localparam logic [1:0] OpRamp = 2'd2;

  // Intensity codes
  localparam logic [1:0] LvlOff    = 2'd0;
  localparam logic [1:0] LvlLow    = 2'd1;
  localparam logic [1:0] LvlMedium = 2'd2;
  localparam logic [1:0] LvlHigh   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgLevelLow    = 2'd0;
  localparam logic [1:0] CfgLevelMedium = 2'd1;
  localparam logic [1:0] CfgLevelHigh   = 2'd2;

  // Register reset values
  localparam logic [7:0] LevelLowReset    = 8'd75;
  localparam logic [7:0] LevelMediumReset = 8'd150;
  localparam logic [7:0] LevelHighReset   = 8'd220;

  // Envelope arithmetic widths
  localparam int unsigned NumW     = 40;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Controller states
  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StMul1,
    StMul2,
    StDiv,
    StWrite
  } tmpe_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic eval;
    logic mul1;
    logic mul2;
    logic div_step;
    logic out_load;
  } tmpe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic fast;
    logic div_last;
    logic out_free;
  } tmpe_stat_t;

  // Map an intensity code to its PWM width
  function automatic logic [7:0] width_of(input logic [1:0] lvl,
                                          input logic [7:0] lo,
                                          input logic [7:0] med,
                                          input logic [7:0] hi);
    logic [7:0] w;
    case (lvl)
      LvlLow:    w = lo;
      LvlMedium: w = med;
      LvlHigh:   w = hi;
      default:   w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/tmpe_in_if.sv =====
// Input channel of the timed motor PWM envelope: valid/ready plus command payload.
// No dependencies.
interface tmpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] time_ms;
  logic [1:0]  level;
  logic [15:0] duration_ms;

  modport source (output valid, output op, output time_ms, output level,
                  output duration_ms, input ready);
  modport sink (input valid, input op, input time_ms, input level,
                input duration_ms, output ready);
endinterface

// ===== hw/rtl/tmpe_out_if.sv =====
// Output channel of the timed motor PWM envelope: valid/ready plus PWM width.
// No dependencies.
interface tmpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_width;

  modport source (output valid, output pwm_width, input ready);
  modport sink (input valid, input pwm_width, output ready);
endinterface

// ===== hw/rtl/tmpe_ctrl.sv =====
// Controller of the timed motor PWM envelope: sequences tick evaluation.
// Depends on tmpe_pkg.
module tmpe_ctrl
  import tmpe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tmpe_stat_t stat_i,
  output tmpe_cmd_t  cmd_o
);

  tmpe_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept && stat_i.is_tick) state_d = StEval;
      StEval:  state_d = stat_i.fast ? StWrite : StMul1;
      StMul1:  state_d = StMul2;
      StMul2:  state_d = StDiv;
      StDiv:   if (stat_i.div_last) state_d = StWrite;
      StWrite: if (stat_i.out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    unique case (state_q)
      StEval:  cmd_o.eval     = 1'b1;
      StMul1:  cmd_o.mul1     = 1'b1;
      StMul2:  cmd_o.mul2     = 1'b1;
      StDiv:   cmd_o.div_step = 1'b1;
      StWrite: cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/tmpe_datapath.sv =====
// Datapath of the timed motor PWM envelope: drive state, level registers, envelope multipliers,
// bit-serial divider and output register. Depends on tmpe_pkg and the assertion macro header.
`include "timed_motor_pwm_envelope_assert.svh"

module tmpe_datapath
  import tmpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tmpe_cmd_t   cmd_i,
  output tmpe_stat_t  stat_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] time_ms_i,
  input  logic [1:0]  level_i,
  input  logic [15:0] duration_ms_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  pwm_width_o
);

  // Level registers
  logic [7:0] level_low_q, level_medium_q, level_high_q;
  // Drive state
  logic [31:0] stop_q, start_q;
  logic        ramp_on_q;
  logic [1:0]  hold_q, peak_q;
  // Tick work registers
  logic [31:0] now_q;
  logic [15:0] e_q, d_q;
  logic [7:0]  fast_w_q;
  logic        slow_q;
  logic [31:0] prod_q, dd_q;
  logic [NumW-1:0] num_q;
  logic [31:0] rem_q;
  logic [CntW-1:0] cnt_q;
  // Output register
  logic        out_valid_q;
  logic [7:0]  out_width_q;

  logic [31:0] e32, span;
  logic [15:0] d_clamp;
  logic        past, ramp_zero, out_free;
  logic [7:0]  peak_w, hold_w, quot_sat;
  logic [NumW-1:0] pp;
  logic [32:0] shifted;
  logic        ge;

  // Level registers, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_low_q    <= LevelLowReset;
      level_medium_q <= LevelMediumReset;
      level_high_q   <= LevelHighReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLevelLow:    level_low_q    <= cfg_data_i;
        CfgLevelMedium: level_medium_q <= cfg_data_i;
        CfgLevelHigh:   level_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Run commands, and ramp commands with a nonzero duration, update the drive state on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q    <= '0;
      start_q   <= '0;
      ramp_on_q <= 1'b0;
      hold_q    <= LvlOff;
      peak_q    <= LvlOff;
    end else if (cmd_i.accept) begin
      case (op_i)
        OpRun: begin
          ramp_on_q <= 1'b0;
          stop_q    <= time_ms_i + {16'd0, duration_ms_i};
          hold_q    <= level_i;
        end
        OpRamp: begin
          if (duration_ms_i != 16'd0) begin
            start_q   <= time_ms_i;
            stop_q    <= time_ms_i + {16'd0, duration_ms_i};
            peak_q    <= level_i;
            ramp_on_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Evaluate the tick against the stop time and ramp window
  assign hold_w  = width_of(hold_q, level_low_q, level_medium_q, level_high_q);
  assign peak_w  = width_of(peak_q, level_low_q, level_medium_q, level_high_q);
  assign e32     = now_q - start_q;
  assign span    = stop_q - start_q;
  assign d_clamp = (span[31:16] != 16'd0) ? 16'hFFFF : span[15:0];
  assign past    = now_q > stop_q;
  assign ramp_zero = (span == 32'd0) || (e32 >= span) || (e32 >= {16'd0, d_clamp});

  // Envelope numerator: 4*e*(d-e)*peak + d*d/2
  assign pp = prod_q * peak_w;

  // One restoring division step per cycle
  assign shifted = {rem_q, num_q[NumW-1]};
  assign ge      = shifted >= {1'b0, dd_q};

  assign quot_sat = (num_q[NumW-1:8] != '0) ? 8'hFF : num_q[7:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q <= time_ms_i;
    end
    if (cmd_i.eval) begin
      e_q      <= e32[15:0];
      d_q      <= d_clamp;
      fast_w_q <= (past || ramp_on_q) ? 8'd0 : hold_w;
      slow_q   <= !(past || !ramp_on_q || ramp_zero);
    end
    if (cmd_i.mul1) begin
      prod_q <= e_q * (d_q - e_q);
      dd_q   <= d_q * d_q;
    end
    if (cmd_i.mul2) begin
      num_q <= {pp[NumW-3:0], 2'b00} + {{(NumW-31){1'b0}}, dd_q[31:1]};
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[NumW-2:0], ge};
      rem_q <= ge ? 32'(shifted - {1'b0, dd_q}) : shifted[31:0];
    end
  end

  // Divider step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mul2) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Output register: hold the result until taken
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_width_q <= slow_q ? quot_sat : fast_w_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pwm_width_o = out_width_q;

  assign stat_o.is_tick  = (op_i == OpTick);
  assign stat_o.fast     = past || !ramp_on_q || ramp_zero;
  assign stat_o.div_last = (cnt_q == CntW'(DivSteps - 1));
  assign stat_o.out_free = out_free;

  // An active ramp always spans 1 to 65535 ms
  `TMPE_ASSERT_IMP(a_ramp_span, clk_i, rst_ni, ramp_on_q, (span[31:16] == 16'd0) && (span != 32'd0), "ramp span out of range")
  // A result is loaded only into a free output register
  `TMPE_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd_i.out_load, out_free, "output overwritten")
  // The envelope quotient fits in the 8-bit width
  `TMPE_ASSERT_IMP(a_quot_fit, clk_i, rst_ni, cmd_i.out_load && slow_q, num_q[NumW-1:8] == '0, "quotient overflow")

endmodule

// ===== hw/rtl/timed_motor_pwm_envelope.sv =====
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   op, time_ms, level, duration_ms
// out_o     out  valid/ready   pwm_width (one per tick)
// cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// Run commands, and ramp commands with a nonzero duration, update the drive state on
// acceptance and leave the controller idle. A tick that needs no envelope (past the
// stop time, fixed mode, or outside the ramp window) passes the eval and write states;
// a ramp tick also passes the multiply and divide states. The width is valid once the
// write state loads it. The one-bit-per-cycle 40-bit divider does most of a ramp tick's work.
// Reset clears the drive state and loads levels 75/150/220.
// A result waits in the output register while commands keep being accepted;
// the next tick is worked out and then holds until that register is free.
//
// Top level of the timed motor PWM envelope; depends on tmpe_pkg, tmpe_in_if,
// tmpe_out_if, tmpe_ctrl and tmpe_datapath.
module timed_motor_pwm_envelope
  import tmpe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tmpe_in_if.sink    in_i,
  tmpe_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  tmpe_cmd_t  cmd;
  tmpe_stat_t stat;

  // Sequence the tick work
  tmpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the state and compute the width
  tmpe_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (in_i.op),
    .time_ms_i     (in_i.time_ms),
    .level_i       (in_i.level),
    .duration_ms_i (in_i.duration_ms),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .pwm_width_o   (out_o.pwm_width)
  );

endmodule
